@@ sv/json_key_stream_filter_defines.svh @@
// Assertion macros for the JSON key stream filter.
// Used by json_key_stream_filter.sv; no other dependencies.
`ifndef JSON_KEY_STREAM_FILTER_DEFINES_SVH
`define JSON_KEY_STREAM_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define JKSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define JKSF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) else $error(msg);
`else
`define JKSF_ASSERT(lbl, prop, msg)
`define JKSF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ sv/jksf_pkg.sv @@
// Shared constants for the JSON key stream filter: filter modes, byte codes and key images.
// No dependencies.
package jksf_pkg;

    localparam int HIST_DEPTH = 8;

    localparam logic [1:0] MODE_PASS        = 2'd0;
    localparam logic [1:0] MODE_SKIP_VALUE  = 2'd1;
    localparam logic [1:0] MODE_TRAIL_FIRST = 2'd2;
    localparam logic [1:0] MODE_TRAIL_REST  = 2'd3;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_L      = 8'h6C;

    // Previous bytes before the ':' of each key, newest first.
    localparam logic [7:0] KEY_IMAGES [HIST_DEPTH] = '{
        8'h22, 8'h73, 8'h65, 8'h67, 8'h61, 8'h6D, 8'h69, 8'h22
    };
    localparam logic [7:0] KEY_TRAIL [HIST_DEPTH-1] = '{
        8'h22, 8'h6C, 8'h69, 8'h61, 8'h72, 8'h74, 8'h22
    };

endpackage

@@ sv/json_key_stream_filter.sv @@
// Path: an accepted input beat is held in the input register, then written to the result register.
// Throughput: one byte per cycle when not stalled; "images": adds four null beats, stalling input.
// Reset (i_rst_n, synchronous, active low) and a start item clear history, mode and nesting.
// Top level of the JSON key stream filter; uses jksf_pkg and json_key_stream_filter_defines.svh.
`include "json_key_stream_filter_defines.svh"

module json_key_stream_filter #(
    parameter int MAX_NESTING = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import jksf_pkg::*;

    localparam int NW = $clog2(MAX_NESTING + 1);
    localparam logic [NW-1:0] NEST_MAX = NW'(MAX_NESTING);

    logic          r_s1_valid;
    logic          r_s1_kind;
    logic [7:0]    r_s1_byte;
    logic [7:0]    r_hist [HIST_DEPTH];
    logic [1:0]    r_mode;
    logic [NW-1:0] r_nest;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic [2:0]    r_null_cnt;

    logic          n_emit;
    logic          n_null;
    logic [1:0]    n_mode;
    logic [NW-1:0] n_nest;
    logic          out_free;
    logic          out_slot;
    logic          s1_fire;
    logic          null_fire;
    logic          hit_images;
    logic          hit_trail;
    logic          is_open;
    logic          is_close;
    logic          st_clear;
    logic [7:0]    c;
    logic [7:0]    null_byte;

    assign c        = r_s1_byte;
    assign out_slot = !r_out_valid || i_ready;
    assign out_free = out_slot && (r_null_cnt == 3'd0);
    assign s1_fire  = r_s1_valid && out_free;
    assign null_fire = out_slot && (r_null_cnt != 3'd0);
    assign o_ready  = !r_s1_valid || s1_fire;
    assign st_clear = (r_mode == MODE_PASS) && (r_nest == '0);

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    always_comb begin
        hit_images = (c == CH_COLON);
        for (int k = 0; k < HIST_DEPTH; k++) begin
            if (r_hist[k] != KEY_IMAGES[k]) begin
                hit_images = 1'b0;
            end
        end
        hit_trail = (c == CH_COLON);
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
            if (r_hist[k] != KEY_TRAIL[k]) begin
                hit_trail = 1'b0;
            end
        end
    end

    assign is_open  = (c == CH_LBRACE) || (c == CH_LBRACK);
    assign is_close = (c == CH_RBRACE) || (c == CH_RBRACK);

    always_comb begin
        n_emit = 1'b0;
        n_null = 1'b0;
        n_mode = r_mode;
        n_nest = r_nest;
        case (r_mode)
            MODE_PASS: begin
                n_emit = 1'b1;
                if (hit_images) begin
                    n_null = 1'b1;
                    n_mode = MODE_SKIP_VALUE;
                    n_nest = '0;
                end else if (hit_trail) begin
                    n_mode = MODE_TRAIL_FIRST;
                    n_nest = '0;
                end
            end
            MODE_SKIP_VALUE: begin
                if (r_nest == '0) begin
                    if (is_open) begin
                        n_nest = NW'(1);
                    end else if (c != CH_SPACE && c != CH_LF && c != CH_CR) begin
                        n_mode = MODE_PASS;
                        n_emit = 1'b1;
                    end
                end else begin
                    if (is_open && r_nest < NEST_MAX) begin
                        n_nest = r_nest + NW'(1);
                    end else if (is_close) begin
                        n_nest = r_nest - NW'(1);
                    end
                    if (n_nest == '0) begin
                        n_mode = MODE_PASS;
                    end
                end
            end
            MODE_TRAIL_FIRST: begin
                n_emit = 1'b1;
                if (c == CH_LBRACE && r_nest < NEST_MAX) begin
                    n_nest = r_nest + NW'(1);
                end else if (c == CH_RBRACE && r_nest != '0) begin
                    n_nest = r_nest - NW'(1);
                end
                if (c == CH_RBRACE && n_nest == '0) begin
                    n_mode = MODE_TRAIL_REST;
                end
                if (c == CH_RBRACK) begin
                    n_mode = MODE_PASS;
                end
            end
            default: begin
                if (c == CH_RBRACK) begin
                    n_emit = 1'b1;
                    n_mode = MODE_PASS;
                end
            end
        endcase
    end

    always_comb begin
        case (r_null_cnt)
            3'd4:    null_byte = CH_N;
            3'd3:    null_byte = CH_U;
            default: null_byte = CH_L;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_kind <= i_kind;
            r_s1_byte <= i_in_byte;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_fire && r_s1_kind)) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_mode <= MODE_PASS;
            r_nest <= '0;
        end else if (s1_fire) begin
            r_hist[0] <= c;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_mode <= n_mode;
            r_nest <= n_nest;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_null_cnt  <= 3'd0;
        end else if (null_fire) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= null_byte;
            r_out_last  <= (r_null_cnt == 3'd1);
            r_null_cnt  <= r_null_cnt - 3'd1;
        end else if (s1_fire && !r_s1_kind && n_emit) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= c;
            r_out_last  <= !n_null;
            r_null_cnt  <= n_null ? 3'd4 : 3'd0;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `JKSF_ASSERT(a_null_needs_out, (r_null_cnt != 3'd0) |-> r_out_valid, "null without beat")
    `JKSF_ASSERT(a_not_last_has_null, (r_out_valid && !r_out_last) |-> |r_null_cnt, "missing null")
    `JKSF_ASSERT(a_nest_bound, r_nest <= NEST_MAX, "nesting above bound")
    `JKSF_ASSERT_NEXT(a_start_clears, s1_fire && r_s1_kind, st_clear, "start not cleared")

endmodule

@@ tb/sv/jksf_checker.sv @@
// Scoreboard for the JSON key stream filter: predicts the filtered byte stream
// from accepted input beats and compares it with accepted output beats.
// Depends on jksf_pkg for the filter modes and byte codes.
module jksf_checker #(
    parameter int MAX_NESTING = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import jksf_pkg::*;

    // newest byte sits in the low byte of the history
    localparam logic [71:0] IMAGES_KEY = "\"images\":";
    localparam logic [63:0] TRAIL_KEY  = "\"trail\":";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    t_out_beat   filtered_q[$];
    logic [71:0] history = '0;
    logic [1:0]  mode    = MODE_PASS;
    logic [8:0]  depth   = '0;
    int          fails   = 0;
    int          checked = 0;

    task automatic note_failure(input string what);
        fails++;
        if (fails <= 10) begin
            $display("mismatch %0d: %s", fails, what);
        end
    endtask

    task automatic filter_byte(input logic [7:0] c);
        logic [7:0] outs [5];
        int         n;
        n = 0;
        history = {history[63:0], c};
        case (mode)
            MODE_PASS: begin
                outs[n] = c;
                n = n + 1;
                if (c == CH_COLON && history == IMAGES_KEY) begin
                    outs[1] = CH_N;
                    outs[2] = CH_U;
                    outs[3] = CH_L;
                    outs[4] = CH_L;
                    n = 5;
                    mode = MODE_SKIP_VALUE;
                    depth = '0;
                end else if (c == CH_COLON && history[63:0] == TRAIL_KEY) begin
                    mode = MODE_TRAIL_FIRST;
                    depth = '0;
                end
            end
            MODE_SKIP_VALUE: begin
                if (depth == 0) begin
                    if (c == CH_LBRACE || c == CH_LBRACK) begin
                        depth = 9'd1;
                    end else if (c != CH_SPACE && c != CH_LF && c != CH_CR) begin
                        mode = MODE_PASS;
                        outs[n] = c;
                        n = n + 1;
                    end
                end else begin
                    if ((c == CH_LBRACE || c == CH_LBRACK) && depth < MAX_NESTING) begin
                        depth = depth + 9'd1;
                    end
                    if ((c == CH_RBRACE || c == CH_RBRACK) && depth > 0) begin
                        depth = depth - 9'd1;
                    end
                    if (depth == 0) begin
                        mode = MODE_PASS;
                    end
                end
            end
            MODE_TRAIL_FIRST: begin
                outs[n] = c;
                n = n + 1;
                if (c == CH_LBRACE && depth < MAX_NESTING) begin
                    depth = depth + 9'd1;
                end
                if (c == CH_RBRACE && depth > 0) begin
                    depth = depth - 9'd1;
                end
                if (depth == 0 && c == CH_RBRACE) begin
                    mode = MODE_TRAIL_REST;
                end
                if (c == CH_RBRACK) begin
                    mode = MODE_PASS;
                end
            end
            default: begin
                if (c == CH_RBRACK) begin
                    outs[n] = c;
                    n = n + 1;
                    mode = MODE_PASS;
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            filtered_q.push_back(t_out_beat'{outs[k], k == n - 1});
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            history = '0;
            mode    = MODE_PASS;
            depth   = '0;
            filtered_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_kind) begin
                    history = '0;
                    mode    = MODE_PASS;
                    depth   = '0;
                end else begin
                    filter_byte(i_in_byte);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    note_failure($sformatf("unexpected beat byte=%02h last=%0b",
                                           i_out_byte, i_out_last));
                end else begin
                    want = filtered_q.pop_front();
                    checked++;
                    if (want.data !== i_out_byte || want.last !== i_out_last) begin
                        note_failure($sformatf("expected byte=%02h last=%0b, got byte=%02h last=%0b",
                                               want.data, want.last, i_out_byte, i_out_last));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= filtered_q.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the JSON key stream filter testbench: clock, reset, byte stimulus and verdict.
// Instantiates json_key_stream_filter and jksf_checker; uses jksf_pkg byte codes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jksf_pkg::*;

    localparam int MAX_NESTING  = 255;
    localparam int RANDOM_BEATS = 165;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_in_beat;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_kind   = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;

    int fail_count;
    int pending;
    int checked;

    t_in_beat stim_q[$];
    int sent_count = 0;
    int hold_at    = 0;
    int cycles     = 0;
    bit hold_done  = 1'b0;
    int n_starts   = 0;
    int n_images   = 0;
    int n_trail    = 0;

    json_key_stream_filter #(.MAX_NESTING(MAX_NESTING)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_kind     (in_kind),
        .i_in_byte  (in_byte),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_out_byte (out_byte),
        .o_last     (out_last)
    );

    jksf_checker #(.MAX_NESTING(MAX_NESTING)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_in_byte    (in_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_out_last   (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic add_byte(input logic [7:0] b);
        stim_q.push_back(t_in_beat'{1'b0, b});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    task automatic add_start();
        stim_q.push_back(t_in_beat'{1'b1, 8'($urandom_range(0, 255))});
        n_starts++;
    endtask

    function automatic logic [7:0] pick_filler(input bit any);
        string set;
        set = "abkz09\":, -";
        if (any && $urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // braces_only builds trail items; otherwise mixed brackets with some raw bytes
    task automatic add_nested(input int lvl, input bit braces_only);
        bit square;
        int cnt;
        square = braces_only ? 1'b0 : 1'($urandom_range(0, 1));
        add_byte(square ? CH_LBRACK : CH_LBRACE);
        cnt = $urandom_range(0, 4);
        for (int k = 0; k < cnt; k++) begin
            if (lvl < 4 && $urandom_range(0, 2) == 0) begin
                add_nested(lvl + 1, braces_only);
            end else begin
                add_byte(pick_filler(!braces_only));
            end
        end
        add_byte(square ? CH_RBRACK : CH_RBRACE);
    endtask

    task automatic build_stimulus();
        string ws;
        string key;
        int    pick;
        int    cnt;
        int    k;
        int    goal;
        ws = " \r\n";

        // directed part
        add_start();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("\"images\":[1,{\"a\":[2]}]x");
        add_text("\"images\": \r\n7,");
        add_text("\"images\":\t");
        add_text("\"trail\":[{\"p\":{1}},{2},{3}]z");
        add_start();
        add_text("\"trail\":}}{a}b]");
        add_text("\"trail\":{{]q");
        add_text("\"imag");
        add_start();
        add_text("es\":");
        n_images += 3;
        n_trail  += 3;
        hold_at = stim_q.size() + 100;

        goal = stim_q.size() + RANDOM_BEATS;
        while (stim_q.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_text("\"images\":");
                n_images++;
                cnt = $urandom_range(0, 2);
                repeat (cnt) add_byte(ws[$urandom_range(0, 2)]);
                if ($urandom_range(0, 3) == 0) begin
                    cnt = $urandom_range(1, 3);
                    repeat (cnt) add_byte(pick_filler(1'b0));
                end else begin
                    add_nested(0, 1'b0);
                end
                add_text(",");
            end else if (pick < 55) begin
                add_text("\"trail\":[");
                n_trail++;
                cnt = $urandom_range(1, 4);
                for (int j = 0; j < cnt; j++) begin
                    if (j > 0) begin
                        add_text(",");
                    end
                    add_nested(0, 1'b1);
                end
                if ($urandom_range(0, 4) == 0) begin
                    add_byte(8'($urandom_range(0, 255)));
                end
                add_byte(CH_RBRACK);
            end else if (pick < 70) begin
                if ($urandom_range(0, 1) == 1) begin
                    key = "\"images\":";
                end else begin
                    key = "\"trail\":";
                end
                k = $urandom_range(0, key.len() - 1);
                for (int i = 0; i < key.len(); i++) begin
                    if (i == k) begin
                        add_byte(8'($urandom_range(0, 255)));
                    end else begin
                        add_byte(key[i]);
                    end
                end
            end else if (pick < 85) begin
                cnt = $urandom_range(1, 8);
                repeat (cnt) add_byte(8'($urandom_range(0, 255)));
            end else if (pick < 93) begin
                add_start();
            end else begin
                cnt = $urandom_range(1, 10);
                repeat (cnt) add_byte(pick_filler(1'b0));
            end
        end
    endtask

    task automatic drive_all();
        int idx;
        int burst;
        int gap;
        idx = 0;
        burst = 0;
        while (idx < stim_q.size()) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid <= 1'b1;
            in_kind  <= stim_q[idx].kind;
            in_byte  <= stim_q[idx].data;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            sent_count++;
            idx++;
            burst--;
        end
        in_valid <= 1'b0;
    endtask

    // output side: stall patterns plus one long hold-off
    initial begin
        int seg;
        int len;
        wait (rst_n);
        forever begin
            if (!hold_done && sent_count >= hold_at) begin
                repeat (HOLD_CYCLES) begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
                hold_done = 1'b1;
            end else begin
                seg = $urandom_range(0, 3);
                len = $urandom_range(5, 60);
                repeat (len) begin
                    case (seg)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ($urandom_range(0, 4) != 0);
                        default: out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        build_stimulus();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        drive_all();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d input beats: %0d starts, %0d images keys, %0d trail keys.",
                 sent_count, n_starts, n_images, n_trail);
        $display("Checked %0d output beats, long output hold-off %0s, %0d mismatches.",
                 checked, hold_done ? "done" : "missed", fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/jksf_pkg.sv
sv/json_key_stream_filter.sv
tb/sv/jksf_checker.sv
tb/sv/testbench.sv
